@@ design/slc_pkg.sv @@
// Shared types, codes and constants of the two-channel light controller.
// Used by every module of the design; depends on nothing else.
`timescale 1ns / 1ps

package slc_pkg;

	typedef enum logic [2:0] {
		CMD_POWER     = 3'd0,
		CMD_BRIGHT    = 3'd1,
		CMD_TEMP_UP   = 3'd2,
		CMD_TEMP_DOWN = 3'd3,
		CMD_TEMP_SET  = 3'd4,
		CMD_MODE      = 3'd5,
		CMD_TOGGLE    = 3'd6,
		CMD_TICK      = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_TIMER = 2'd2,
		ST_NONE  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		PWM_KEEP = 2'd0,
		PWM_LOAD = 2'd1,
		PWM_ZERO = 2'd2
	} pwm_act_t;

	typedef enum logic [1:0] {
		REG_BLINK_PERIOD = 2'd0,
		REG_TIMER_SHORT  = 2'd1,
		REG_TIMER_MEDIUM = 2'd2,
		REG_TIMER_LONG   = 2'd3
	} cfg_reg_t;

	localparam int unsigned CHG_POWER  = 0;
	localparam int unsigned CHG_BRIGHT = 1;
	localparam int unsigned CHG_TEMP   = 2;
	localparam int unsigned CHG_BLINK  = 3;
	localparam int unsigned CHG_TIMER  = 4;

	localparam int unsigned CFG_W    = 22;
	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned TIMER_W  = 22;

	localparam logic [PERIOD_W-1:0] BLINK_PERIOD_RST = 16'd1500;
	localparam logic [TIMER_W-1:0]  TIMER_SHORT_RST  = 22'd300000;
	localparam logic [TIMER_W-1:0]  TIMER_MEDIUM_RST = 22'd600000;
	localparam logic [TIMER_W-1:0]  TIMER_LONG_RST   = 22'd3600000;

	localparam logic [7:0] TIMER_INSTANCE = 8'd12;
	localparam logic [7:0] BLINK_INSTANCE = 8'd2;
	localparam logic [6:0] MAX_BRIGHT     = 7'd100;
	localparam int unsigned TEMP_COUNT    = 5;
	localparam logic [2:0] TEMP_LAST      = 3'd4;

	// floor(255 * p / 10000) equals (p * PWM_RECIP) >> PWM_SHIFT for p up to 10000.
	localparam logic [19:0] PWM_RECIP = 20'd855639;
	localparam int unsigned PWM_SHIFT = 25;

	typedef struct packed {
		cmd_t               cmd;
		logic [15:0]        correlation_id;
		logic               is_delta;
		logic signed [7:0]  value;
		logic               on_flag;
		logic [7:0]         instance_req;
		logic [15:0]        kelvin;
		logic [15:0]        elapsed_ms;
	} item_t;

	typedef struct packed {
		logic [15:0] correlation_id;
		status_t     status;
		logic [4:0]  changed_bits;
		logic        power_on;
		logic [6:0]  brightness;
		logic [2:0]  temp_index;
		logic [7:0]  timer_mode;
		logic        blink_on;
		pwm_act_t    pwm_act;
		logic [13:0] warm_prod;
		logic [13:0] cold_prod;
	} result_t;

	function automatic logic [6:0] duty_warm(input logic [2:0] idx);
		logic [6:0] d;
		case (idx)
			3'd0: d = 7'd100;
			3'd1: d = 7'd84;
			3'd2: d = 7'd49;
			3'd3: d = 7'd25;
			default: d = 7'd0;
		endcase
		return d;
	endfunction

	function automatic logic [6:0] duty_cold(input logic [2:0] idx);
		logic [6:0] d;
		case (idx)
			3'd0: d = 7'd0;
			3'd1: d = 7'd16;
			3'd2: d = 7'd51;
			3'd3: d = 7'd75;
			default: d = 7'd100;
		endcase
		return d;
	endfunction

	function automatic logic [15:0] temp_kelvin(input logic [2:0] idx);
		logic [15:0] k;
		case (idx)
			3'd0: k = 16'd2200;
			3'd1: k = 16'd2700;
			3'd2: k = 16'd4000;
			3'd3: k = 16'd5500;
			3'd4: k = 16'd7000;
			default: k = 16'd0;
		endcase
		return k;
	endfunction

	function automatic logic [7:0] pwm_scale(input logic [13:0] prod);
		logic [33:0] full;
		full = {20'd0, prod} * {14'd0, PWM_RECIP};
		return full[PWM_SHIFT +: 8];
	endfunction

endpackage

@@ design/slc_in_reg.sv @@
// Input register stage of the light controller: holds one accepted item.
// Depends on slc_pkg for the item type.
`timescale 1ns / 1ps

module slc_in_reg
	import slc_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  req_valid,
	output logic  req_ready,
	input  item_t req_item,
	input  logic  down_ready,
	output logic  valid_s1,
	output item_t item_s1
);

	assign req_ready = !valid_s1 || down_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			item_s1 <= req_item;
		end
	end

endmodule

@@ design/slc_core.sv @@
// Command stage of the light controller: configuration registers, light state
// and the update for one item, with the duty-times-brightness products.
// Depends on slc_pkg.
`timescale 1ns / 1ps

module slc_core
	import slc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             valid_s1,
	input  item_t            item_s1,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             down_ready,
	output logic             up_ready,
	output logic             valid_s2,
	output result_t          res_s2
);

	localparam int unsigned SCNT_W = TIMER_W + 1;
	localparam int unsigned BCNT_W = PERIOD_W + 2;

	logic [PERIOD_W-1:0] period_q;
	logic [TIMER_W-1:0]  tshort_q;
	logic [TIMER_W-1:0]  tmedium_q;
	logic [TIMER_W-1:0]  tlong_q;

	logic                     pwr_q;
	logic [6:0]               bri_q;
	logic [2:0]               tidx_q;
	logic [7:0]               smode_q;
	logic signed [SCNT_W-1:0] scnt_q;
	logic                     bmode_q;
	logic signed [BCNT_W-1:0] bcnt_q;
	logic                     bphase_q;

	logic                     n_pwr;
	logic [6:0]               n_bri;
	logic [2:0]               n_tidx;
	logic [7:0]               n_smode;
	logic signed [SCNT_W-1:0] n_scnt;
	logic                     n_bmode;
	logic signed [BCNT_W-1:0] n_bcnt;
	logic                     n_bphase;
	status_t                  n_status;
	logic [4:0]               n_bits;
	pwm_act_t                 n_act;

	logic signed [9:0] bri_sum;
	logic signed [9:0] mode_sum;
	logic              set_hit;
	logic [2:0]        set_idx;
	logic              temp_change;
	logic [2:0]        temp_new;
	logic              advance;

	assign up_ready = !valid_s2 || down_ready;
	assign advance  = valid_s1 && up_ready;

	assign bri_sum  = $signed({3'b000, bri_q}) + $signed({{2{item_s1.value[7]}}, item_s1.value});
	assign mode_sum = $signed({2'b00, smode_q}) + $signed({{2{item_s1.value[7]}}, item_s1.value});

	always_comb begin
		set_hit = 1'b0;
		set_idx = '0;
		for (int i = 0; i < TEMP_COUNT; i++) begin
			if (!set_hit && item_s1.kelvin == temp_kelvin(3'(i))) begin
				set_hit = 1'b1;
				set_idx = 3'(i);
			end
		end
	end

	always_comb begin
		temp_change = 1'b0;
		temp_new    = tidx_q;
		case (item_s1.cmd)
			CMD_TEMP_UP: begin
				temp_change = (tidx_q != TEMP_LAST);
				temp_new    = tidx_q + 3'd1;
			end
			CMD_TEMP_DOWN: begin
				temp_change = (tidx_q != 3'd0);
				temp_new    = tidx_q - 3'd1;
			end
			CMD_TEMP_SET: begin
				temp_change = set_hit && (tidx_q != set_idx);
				temp_new    = set_idx;
			end
			default: begin
				temp_change = 1'b0;
				temp_new    = tidx_q;
			end
		endcase
	end

	always_comb begin
		n_pwr    = pwr_q;
		n_bri    = bri_q;
		n_tidx   = tidx_q;
		n_smode  = smode_q;
		n_scnt   = scnt_q;
		n_bmode  = bmode_q;
		n_bcnt   = bcnt_q;
		n_bphase = bphase_q;
		n_status = ST_OK;
		n_bits   = '0;
		n_act    = PWM_KEEP;
		case (item_s1.cmd)
			CMD_POWER: begin
				if (pwr_q != item_s1.on_flag) begin
					if (smode_q != '0) begin
						n_smode           = '0;
						n_bits[CHG_TIMER] = 1'b1;
					end
					if (bmode_q) begin
						n_bmode           = 1'b0;
						n_bcnt            = '0;
						n_bits[CHG_BLINK] = 1'b1;
					end
					n_bits[CHG_POWER] = 1'b1;
					n_pwr             = item_s1.on_flag;
					n_act             = item_s1.on_flag ? PWM_LOAD : PWM_ZERO;
				end
			end
			CMD_BRIGHT: begin
				if (item_s1.is_delta) begin
					if (bri_sum > $signed({3'b000, MAX_BRIGHT})) begin
						if (bri_q != MAX_BRIGHT) begin
							n_bri              = MAX_BRIGHT;
							n_bits[CHG_BRIGHT] = 1'b1;
						end
					end else if (bri_sum[9]) begin
						if (bri_q != '0) begin
							n_bri              = '0;
							n_bits[CHG_BRIGHT] = 1'b1;
						end
					end else begin
						n_bri              = bri_sum[6:0];
						n_bits[CHG_BRIGHT] = 1'b1;
					end
				end else if (item_s1.value[7] || item_s1.value > $signed({1'b0, MAX_BRIGHT})) begin
					n_status = ST_RANGE;
				end else if ({1'b0, bri_q} != item_s1.value) begin
					n_bri              = item_s1.value[6:0];
					n_bits[CHG_BRIGHT] = 1'b1;
				end
				if (n_bits[CHG_BRIGHT]) begin
					n_pwr             = 1'b1;
					n_bits[CHG_POWER] = !pwr_q;
					n_act             = PWM_LOAD;
				end
			end
			CMD_TEMP_UP, CMD_TEMP_DOWN, CMD_TEMP_SET: begin
				if (temp_change) begin
					n_tidx            = temp_new;
					n_bits[CHG_TEMP]  = 1'b1;
					n_pwr             = 1'b1;
					n_bits[CHG_POWER] = !pwr_q;
					n_act             = PWM_LOAD;
				end
			end
			CMD_MODE: begin
				if (item_s1.instance_req != TIMER_INSTANCE) begin
					n_status = ST_NONE;
				end else begin
					if (item_s1.is_delta) begin
						if (mode_sum[9] || mode_sum > 10'sd3) begin
							n_status = ST_RANGE;
						end else begin
							n_smode           = mode_sum[7:0];
							n_bits[CHG_TIMER] = 1'b1;
						end
					end else if ({1'b0, smode_q} != {item_s1.value[7], item_s1.value}) begin
						n_smode           = item_s1.value[7:0];
						n_bits[CHG_TIMER] = 1'b1;
					end
					if (n_bits[CHG_TIMER]) begin
						if (!pwr_q) begin
							n_pwr             = 1'b1;
							n_bits[CHG_POWER] = 1'b1;
							n_act             = PWM_LOAD;
						end
						case (n_smode)
							8'd1: n_scnt = $signed({1'b0, tshort_q});
							8'd2: n_scnt = $signed({1'b0, tmedium_q});
							8'd3: n_scnt = $signed({1'b0, tlong_q});
							default: n_scnt = '0;
						endcase
					end
				end
			end
			CMD_TOGGLE: begin
				if (item_s1.instance_req != BLINK_INSTANCE) begin
					n_status = ST_NONE;
				end else if (bmode_q != item_s1.on_flag) begin
					n_bmode           = item_s1.on_flag;
					n_bits[CHG_BLINK] = 1'b1;
					n_bphase          = 1'b1;
					if (!pwr_q) begin
						n_pwr             = 1'b1;
						n_bits[CHG_POWER] = 1'b1;
						n_act             = PWM_LOAD;
					end
				end
			end
			default: begin
				n_status = ST_NONE;
				if (smode_q != '0) begin
					if (scnt_q[SCNT_W-1] || scnt_q == '0) begin
						n_scnt            = '0;
						n_smode           = '0;
						n_pwr             = 1'b0;
						n_bits[CHG_TIMER] = 1'b1;
						n_bits[CHG_POWER] = 1'b1;
						n_act             = PWM_ZERO;
						n_status          = ST_TIMER;
						if (bmode_q) begin
							n_bmode           = 1'b0;
							n_bcnt            = '0;
							n_bits[CHG_BLINK] = 1'b1;
						end
					end else begin
						n_scnt = scnt_q - $signed({7'd0, item_s1.elapsed_ms});
					end
				end
				if (n_bmode) begin
					if (bcnt_q[BCNT_W-1] || bcnt_q == '0) begin
						n_act    = bphase_q ? PWM_ZERO : PWM_LOAD;
						n_bphase = !bphase_q;
						n_bcnt   = $signed({2'b00, period_q});
					end else begin
						n_bcnt = bcnt_q - $signed({2'b00, item_s1.elapsed_ms});
					end
				end
			end
		endcase
		if (n_status == ST_RANGE || n_status == ST_NONE) begin
			n_bits = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q  <= BLINK_PERIOD_RST;
			tshort_q  <= TIMER_SHORT_RST;
			tmedium_q <= TIMER_MEDIUM_RST;
			tlong_q   <= TIMER_LONG_RST;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				REG_BLINK_PERIOD: period_q  <= cfg_wdata[PERIOD_W-1:0];
				REG_TIMER_SHORT:  tshort_q  <= cfg_wdata[TIMER_W-1:0];
				REG_TIMER_MEDIUM: tmedium_q <= cfg_wdata[TIMER_W-1:0];
				REG_TIMER_LONG:   tlong_q   <= cfg_wdata[TIMER_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pwr_q    <= 1'b0;
			bri_q    <= MAX_BRIGHT;
			tidx_q   <= '0;
			smode_q  <= '0;
			scnt_q   <= '0;
			bmode_q  <= 1'b0;
			bcnt_q   <= '0;
			bphase_q <= 1'b0;
		end else if (advance) begin
			pwr_q    <= n_pwr;
			bri_q    <= n_bri;
			tidx_q   <= n_tidx;
			smode_q  <= n_smode;
			scnt_q   <= n_scnt;
			bmode_q  <= n_bmode;
			bcnt_q   <= n_bcnt;
			bphase_q <= n_bphase;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (up_ready) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2.correlation_id <= item_s1.correlation_id;
			res_s2.status         <= n_status;
			res_s2.changed_bits   <= n_bits;
			res_s2.power_on       <= n_pwr;
			res_s2.brightness     <= n_bri;
			res_s2.temp_index     <= n_tidx;
			res_s2.timer_mode     <= n_smode;
			res_s2.blink_on       <= n_bmode;
			res_s2.pwm_act        <= n_act;
			res_s2.warm_prod      <= {7'd0, duty_warm(n_tidx)} * {7'd0, n_bri};
			res_s2.cold_prod      <= {7'd0, duty_cold(n_tidx)} * {7'd0, n_bri};
		end
	end

endmodule

@@ design/slc_out_stage.sv @@
// Result stage of the light controller: scales the products to PWM levels,
// keeps the level registers and holds the result item for the receiver.
// Depends on slc_pkg.
`timescale 1ns / 1ps

module slc_out_stage
	import slc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       valid_s2,
	input  result_t    res_s2,
	output logic       up_ready,
	output logic       rsp_valid,
	input  logic       rsp_ready,
	output result_t    res_s3,
	output logic [7:0] warm_q,
	output logic [7:0] cold_q
);

	logic advance;

	assign up_ready = !rsp_valid || rsp_ready;
	assign advance  = valid_s2 && up_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (up_ready) begin
			rsp_valid <= valid_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			warm_q <= '0;
			cold_q <= '0;
		end else if (advance) begin
			case (res_s2.pwm_act)
				PWM_LOAD: begin
					warm_q <= pwm_scale(res_s2.warm_prod);
					cold_q <= pwm_scale(res_s2.cold_prod);
				end
				PWM_ZERO: begin
					warm_q <= '0;
					cold_q <= '0;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s3 <= res_s2;
		end
	end

endmodule

@@ design/smart_light_controller.sv @@
// Top level of the two-channel warm/cold light controller.
// Instantiates slc_in_reg, slc_core and slc_out_stage; depends on slc_pkg.
//
// Usage:
// Commands enter on the req channel (req_valid/req_ready) and each one gives
// exactly one result item on the rsp channel (rsp_valid/rsp_ready), in order.
// The pipeline has three register stages: an input register, the command
// stage that updates the light state and forms duty times brightness, and a
// result stage that scales this to PWM levels. An accepted item is registered
// in the command stage and then in the result stage before its result is
// offered, and one item is taken every cycle while the receiver keeps up.
// When the receiver stalls, the result stage holds its item and the earlier
// stages keep filling, so up to three items are in flight before req_ready
// falls. The configuration port writes one register per cycle with no wait;
// the user must write it while no item is in flight; nothing checks this.
// Reset clears all stages, turns the light off at full brightness and
// 2200 K, and restores the default blink period and shutoff times.
`timescale 1ns / 1ps

module smart_light_controller
	import slc_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [CFG_W-1:0] cfg_wdata,
	input  logic             req_valid,
	output logic             req_ready,
	input  logic [2:0]       cmd,
	input  logic [15:0]      correlation_id,
	input  logic             is_delta,
	input  logic signed [7:0] value,
	input  logic             on_flag,
	input  logic [7:0]       instance_req,
	input  logic [15:0]      kelvin,
	input  logic [15:0]      elapsed_ms,
	output logic             rsp_valid,
	input  logic             rsp_ready,
	output logic [15:0]      correlation_id_out,
	output logic [1:0]       status,
	output logic [4:0]       changed_bits,
	output logic             power_on,
	output logic [6:0]       brightness_out,
	output logic [2:0]       temp_index,
	output logic [7:0]       timer_mode_out,
	output logic             blink_on,
	output logic [7:0]       warm_level,
	output logic [7:0]       cold_level
);

	item_t   req_item;
	item_t   item_s1;
	logic    valid_s1;
	logic    ready_s1;
	logic    valid_s2;
	result_t res_s2;
	logic    ready_s2;
	result_t res_s3;

	always_comb begin
		req_item.cmd            = cmd_t'(cmd);
		req_item.correlation_id = correlation_id;
		req_item.is_delta       = is_delta;
		req_item.value          = value;
		req_item.on_flag        = on_flag;
		req_item.instance_req   = instance_req;
		req_item.kelvin         = kelvin;
		req_item.elapsed_ms     = elapsed_ms;
	end

	slc_in_reg u_in_reg (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_ready  (req_ready),
		.req_item   (req_item),
		.down_ready (ready_s1),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1)
	);

	slc_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.valid_s1   (valid_s1),
		.item_s1    (item_s1),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.down_ready (ready_s2),
		.up_ready   (ready_s1),
		.valid_s2   (valid_s2),
		.res_s2     (res_s2)
	);

	slc_out_stage u_out_stage (
		.clk       (clk),
		.arst_n    (arst_n),
		.valid_s2  (valid_s2),
		.res_s2    (res_s2),
		.up_ready  (ready_s2),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.res_s3    (res_s3),
		.warm_q    (warm_level),
		.cold_q    (cold_level)
	);

	assign correlation_id_out = res_s3.correlation_id;
	assign status             = res_s3.status;
	assign changed_bits       = res_s3.changed_bits;
	assign power_on           = res_s3.power_on;
	assign brightness_out     = res_s3.brightness;
	assign temp_index         = res_s3.temp_index;
	assign timer_mode_out     = res_s3.timer_mode;
	assign blink_on           = res_s3.blink_on;

endmodule

@@ design/slc_checker.sv @@
// Port-level checks for the light controller, bound to the top level.
// Depends on slc_pkg and the port names of smart_light_controller.
`timescale 1ns / 1ps

module slc_checker
	import slc_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic [15:0] correlation_id_out,
	input logic [1:0]  status,
	input logic [4:0]  changed_bits,
	input logic        power_on,
	input logic [6:0]  brightness_out,
	input logic [2:0]  temp_index,
	input logic [7:0]  timer_mode_out,
	input logic        blink_on,
	input logic [7:0]  warm_level,
	input logic [7:0]  cold_level
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(correlation_id_out) && $stable(status))
		else $error("result item changed while stalled");

	a_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_RANGE || status == ST_NONE) |-> changed_bits == '0)
		else $error("change bits reported with an error or silent status");

	a_dark: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !power_on |-> warm_level == '0 && cold_level == '0 && !blink_on)
		else $error("light off but levels or blink active");

	a_shutoff: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == ST_TIMER |->
			changed_bits[CHG_POWER] && changed_bits[CHG_TIMER] && !power_on &&
			timer_mode_out == '0)
		else $error("shutoff report inconsistent with state");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> brightness_out <= MAX_BRIGHT && temp_index <= TEMP_LAST)
		else $error("brightness or colour temperature index out of range");

endmodule

bind smart_light_controller slc_checker u_slc_checker (.*);

@@ test/smart_light_controller_test.sv @@
// Self-checking testbench for the two-channel warm/cold light controller.
// Drives a directed table, then random commands; checks each result against typed
// table rows or a model of the light state. Depends on slc_pkg and the design.
`timescale 1ns / 1ps

module smart_light_controller_test;
	import slc_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int PHASE_COUNT = 8;
	localparam int ITEMS_PER_PHASE = 225;
	localparam logic [7:0] TIMER_INST = 8'd12;
	localparam logic [7:0] BLINK_INST = 8'd2;
	localparam int FULL_BRIGHT = 100;
	localparam int WARM_DUTY [5] = '{100, 84, 49, 25, 0};
	localparam int COLD_DUTY [5] = '{0, 16, 51, 75, 100};
	localparam int KELVIN_STEPS [5] = '{2200, 2700, 4000, 5500, 7000};

	typedef struct {
		logic [15:0] tag;
		status_t     status;
		logic [4:0]  changed;
		logic        power;
		logic [6:0]  bright;
		logic [2:0]  temp;
		logic [7:0]  timer_mode;
		logic        blink;
		logic [7:0]  warm;
		logic [7:0]  cold;
	} light_report_t;

	typedef struct {
		item_t         item;
		bit            typed;
		light_report_t want;
	} script_row_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [1:0] cfg_index;
	logic [CFG_W-1:0] cfg_wdata;
	logic req_valid;
	logic req_ready;
	logic [2:0] cmd;
	logic [15:0] correlation_id;
	logic is_delta;
	logic signed [7:0] value;
	logic on_flag;
	logic [7:0] instance_req;
	logic [15:0] kelvin;
	logic [15:0] elapsed_ms;
	logic rsp_valid;
	logic rsp_ready;
	logic [15:0] correlation_id_out;
	logic [1:0] status;
	logic [4:0] changed_bits;
	logic power_on;
	logic [6:0] brightness_out;
	logic [2:0] temp_index;
	logic [7:0] timer_mode_out;
	logic blink_on;
	logic [7:0] warm_level;
	logic [7:0] cold_level;

	// Model of the light state and of the configuration registers.
	logic lamp_on;
	logic [6:0] lamp_bright;
	logic [2:0] lamp_temp;
	logic [7:0] shutoff_mode;
	int shutoff_left;
	logic blink_mode;
	logic blink_phase;
	int blink_left;
	logic [7:0] warm_lvl;
	logic [7:0] cold_lvl;
	logic [15:0] cfg_blink_period;
	logic [21:0] cfg_short;
	logic [21:0] cfg_medium;
	logic [21:0] cfg_long;

	light_report_t expected_reports[$];
	light_report_t arrived_want;
	script_row_t script[$];
	int mismatch_count = 0;
	int quiet_cycles = 0;
	int send_idle_pct = 0;
	int stall_pct = 0;

	smart_light_controller i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.cmd(cmd),
		.correlation_id(correlation_id),
		.is_delta(is_delta),
		.value(value),
		.on_flag(on_flag),
		.instance_req(instance_req),
		.kelvin(kelvin),
		.elapsed_ms(elapsed_ms),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.correlation_id_out(correlation_id_out),
		.status(status),
		.changed_bits(changed_bits),
		.power_on(power_on),
		.brightness_out(brightness_out),
		.temp_index(temp_index),
		.timer_mode_out(timer_mode_out),
		.blink_on(blink_on),
		.warm_level(warm_level),
		.cold_level(cold_level)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic bit chance(input int pct);
		return $urandom_range(99, 0) < pct;
	endfunction

	function automatic item_t command(input cmd_t op, input bit delta, input int val,
			input bit on, input int inst, input int k, input int gap);
		item_t c;
		c.cmd = op;
		c.correlation_id = 16'd0;
		c.is_delta = delta;
		c.value = 8'(val);
		c.on_flag = on;
		c.instance_req = 8'(inst);
		c.kelvin = 16'(k);
		c.elapsed_ms = 16'(gap);
		return c;
	endfunction

	function automatic light_report_t state_after(input status_t st, input logic [4:0] chg,
			input logic pwr, input int br, input int tp, input int md, input logic bl,
			input int wm, input int cd);
		light_report_t r;
		r.tag = 16'd0;
		r.status = st;
		r.changed = chg;
		r.power = pwr;
		r.bright = 7'(br);
		r.temp = 3'(tp);
		r.timer_mode = 8'(md);
		r.blink = bl;
		r.warm = 8'(wm);
		r.cold = 8'(cd);
		return r;
	endfunction

	function automatic script_row_t typed_row(input item_t c, input light_report_t want);
		script_row_t r;
		r.item = c;
		r.typed = 1'b1;
		r.want = want;
		return r;
	endfunction

	function automatic script_row_t open_row(input item_t c);
		script_row_t r;
		r.item = c;
		r.typed = 1'b0;
		return r;
	endfunction

	function automatic void load_levels();
		warm_lvl = 8'((255 * WARM_DUTY[lamp_temp] * int'(lamp_bright)) / 10000);
		cold_lvl = 8'((255 * COLD_DUTY[lamp_temp] * int'(lamp_bright)) / 10000);
	endfunction

	function automatic void light_up(inout logic [4:0] chg);
		if (!lamp_on) begin
			lamp_on = 1'b1;
			chg[CHG_POWER] = 1'b1;
			load_levels();
		end
	endfunction

	function automatic void shift_temp(input int idx, inout logic [4:0] chg);
		lamp_temp = 3'(idx);
		chg[CHG_TEMP] = 1'b1;
		if (!lamp_on) begin
			lamp_on = 1'b1;
			chg[CHG_POWER] = 1'b1;
		end
		load_levels();
	endfunction

	function automatic void drop_blink(inout logic [4:0] chg);
		if (blink_mode) begin
			blink_mode = 1'b0;
			blink_left = 0;
			chg[CHG_BLINK] = 1'b1;
		end
	endfunction

	function automatic light_report_t apply_command(input item_t c);
		light_report_t r;
		status_t st;
		logic [4:0] chg;
		int v;
		int s;
		st = ST_OK;
		chg = '0;
		v = int'($signed(c.value));
		case (c.cmd)
			CMD_POWER: begin
				if (lamp_on != c.on_flag) begin
					if (shutoff_mode != 8'd0) begin
						shutoff_mode = 8'd0;
						chg[CHG_TIMER] = 1'b1;
					end
					drop_blink(chg);
					chg[CHG_POWER] = 1'b1;
					lamp_on = c.on_flag;
					if (c.on_flag) begin
						load_levels();
					end else begin
						warm_lvl = 8'd0;
						cold_lvl = 8'd0;
					end
				end
			end
			CMD_BRIGHT: begin
				if (c.is_delta) begin
					s = int'(lamp_bright) + v;
					if (s > FULL_BRIGHT) begin
						if (int'(lamp_bright) != FULL_BRIGHT) begin
							lamp_bright = 7'(FULL_BRIGHT);
							chg[CHG_BRIGHT] = 1'b1;
						end
					end else if (s < 0) begin
						if (lamp_bright != 7'd0) begin
							lamp_bright = 7'd0;
							chg[CHG_BRIGHT] = 1'b1;
						end
					end else begin
						lamp_bright = 7'(s);
						chg[CHG_BRIGHT] = 1'b1;
					end
				end else if (v > FULL_BRIGHT || v < 0) begin
					st = ST_RANGE;
				end else if (int'(lamp_bright) != v) begin
					lamp_bright = 7'(v);
					chg[CHG_BRIGHT] = 1'b1;
				end
				if (chg != 5'd0) begin
					if (!lamp_on) begin
						lamp_on = 1'b1;
						chg[CHG_POWER] = 1'b1;
					end
					load_levels();
				end
			end
			CMD_TEMP_UP: begin
				if (lamp_temp != 3'd4) shift_temp(int'(lamp_temp) + 1, chg);
			end
			CMD_TEMP_DOWN: begin
				if (lamp_temp != 3'd0) shift_temp(int'(lamp_temp) - 1, chg);
			end
			CMD_TEMP_SET: begin
				for (int i = 0; i < 5; i++) begin
					if (int'(c.kelvin) == KELVIN_STEPS[i] && int'(lamp_temp) != i) begin
						shift_temp(i, chg);
					end
				end
			end
			CMD_MODE: begin
				if (c.instance_req != TIMER_INST) begin
					st = ST_NONE;
				end else begin
					if (c.is_delta) begin
						s = int'(shutoff_mode) + v;
						if (s > 3 || s < 0) begin
							st = ST_RANGE;
						end else begin
							shutoff_mode = 8'(s);
							chg[CHG_TIMER] = 1'b1;
						end
					end else if (int'(shutoff_mode) != v) begin
						shutoff_mode = 8'(v);
						chg[CHG_TIMER] = 1'b1;
					end
					if (chg != 5'd0) begin
						light_up(chg);
						case (shutoff_mode)
							8'd1: shutoff_left = int'(cfg_short);
							8'd2: shutoff_left = int'(cfg_medium);
							8'd3: shutoff_left = int'(cfg_long);
							default: shutoff_left = 0;
						endcase
					end
				end
			end
			CMD_TOGGLE: begin
				if (c.instance_req != BLINK_INST) begin
					st = ST_NONE;
				end else if (blink_mode != c.on_flag) begin
					blink_mode = c.on_flag;
					chg[CHG_BLINK] = 1'b1;
					light_up(chg);
					blink_phase = 1'b1;
				end
			end
			default: begin
				st = ST_NONE;
				if (shutoff_mode != 8'd0) begin
					if (shutoff_left <= 0) begin
						shutoff_left = 0;
						shutoff_mode = 8'd0;
						lamp_on = 1'b0;
						chg[CHG_POWER] = 1'b1;
						chg[CHG_TIMER] = 1'b1;
						drop_blink(chg);
						warm_lvl = 8'd0;
						cold_lvl = 8'd0;
						st = ST_TIMER;
					end else begin
						shutoff_left -= int'(c.elapsed_ms);
					end
				end
				if (blink_mode) begin
					if (blink_left <= 0) begin
						if (blink_phase) begin
							warm_lvl = 8'd0;
							cold_lvl = 8'd0;
							blink_phase = 1'b0;
						end else begin
							load_levels();
							blink_phase = 1'b1;
						end
						blink_left = int'(cfg_blink_period);
					end else begin
						blink_left -= int'(c.elapsed_ms);
					end
				end
			end
		endcase
		if (st == ST_RANGE || st == ST_NONE) chg = '0;
		r.tag = c.correlation_id;
		r.status = st;
		r.changed = chg;
		r.power = lamp_on;
		r.bright = lamp_bright;
		r.temp = lamp_temp;
		r.timer_mode = shutoff_mode;
		r.blink = blink_mode;
		r.warm = warm_lvl;
		r.cold = cold_lvl;
		return r;
	endfunction

	function automatic item_t random_command();
		item_t c;
		int pick;
		c.correlation_id = 16'($urandom);
		c.is_delta = 1'($urandom);
		c.value = 8'($urandom);
		c.on_flag = 1'($urandom);
		c.instance_req = 8'($urandom);
		c.kelvin = 16'($urandom);
		c.elapsed_ms = 16'($urandom);
		pick = $urandom_range(99, 0);
		if (pick < 10) c.cmd = CMD_POWER;
		else if (pick < 25) c.cmd = CMD_BRIGHT;
		else if (pick < 33) c.cmd = CMD_TEMP_UP;
		else if (pick < 41) c.cmd = CMD_TEMP_DOWN;
		else if (pick < 49) c.cmd = CMD_TEMP_SET;
		else if (pick < 61) c.cmd = CMD_MODE;
		else if (pick < 70) c.cmd = CMD_TOGGLE;
		else c.cmd = CMD_TICK;
		case (c.cmd)
			CMD_BRIGHT: begin
				if (!c.is_delta && chance(80)) c.value = 8'($urandom_range(100, 0));
				if (c.is_delta && chance(60)) c.value = 8'(int'($urandom_range(60, 0)) - 30);
			end
			CMD_TEMP_SET: begin
				if (chance(75)) c.kelvin = 16'(KELVIN_STEPS[$urandom_range(4, 0)]);
			end
			CMD_MODE: begin
				if (chance(85)) c.instance_req = TIMER_INST;
				if (c.is_delta && chance(70)) c.value = 8'(int'($urandom_range(6, 0)) - 3);
				if (!c.is_delta && chance(80)) c.value = 8'($urandom_range(3, 0));
			end
			CMD_TOGGLE: begin
				if (chance(85)) c.instance_req = BLINK_INST;
			end
			CMD_TICK: begin
				case ($urandom_range(3, 0))
					0: c.elapsed_ms = 16'($urandom_range(50, 0));
					1: c.elapsed_ms = 16'($urandom_range(3000, 0));
					2: c.elapsed_ms = 16'($urandom);
					default: c.elapsed_ms = chance(50) ? 16'hFFFF : 16'h0000;
				endcase
			end
			default: begin
			end
		endcase
		return c;
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		$display("%0t: mismatch: %s", $time, what);
	endtask

	task automatic check_field(input string name, input logic [15:0] got,
			input logic [15:0] want);
		if (got !== want) begin
			report_mismatch($sformatf("%s is %0h, %0h expected", name, got, want));
		end
	endtask

	task automatic send_command(input script_row_t row);
		light_report_t want;
		while (chance(send_idle_pct)) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid <= 1'b1;
		cmd <= row.item.cmd;
		correlation_id <= row.item.correlation_id;
		is_delta <= row.item.is_delta;
		value <= row.item.value;
		on_flag <= row.item.on_flag;
		instance_req <= row.item.instance_req;
		kelvin <= row.item.kelvin;
		elapsed_ms <= row.item.elapsed_ms;
		do @(posedge clk); while (!req_ready);
		want = apply_command(row.item);
		if (row.typed) begin
			want = row.want;
			want.tag = row.item.correlation_id;
		end
		expected_reports.push_back(want);
		@(negedge clk);
	endtask

	task automatic load_settings(input logic [15:0] period, input logic [21:0] t_short,
			input logic [21:0] t_medium, input logic [21:0] t_long);
		cfg_we <= 1'b1;
		cfg_index <= REG_BLINK_PERIOD;
		cfg_wdata <= {6'($urandom), period};
		@(negedge clk);
		cfg_index <= REG_TIMER_SHORT;
		cfg_wdata <= t_short;
		@(negedge clk);
		cfg_index <= REG_TIMER_MEDIUM;
		cfg_wdata <= t_medium;
		@(negedge clk);
		cfg_index <= REG_TIMER_LONG;
		cfg_wdata <= t_long;
		@(negedge clk);
		cfg_we <= 1'b0;
		cfg_blink_period = period;
		cfg_short = t_short;
		cfg_medium = t_medium;
		cfg_long = t_long;
	endtask

	initial begin
		rsp_ready = 1'b0;
		forever begin
			@(negedge clk);
			rsp_ready <= !chance(stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_reports.size() == 0) begin
				report_mismatch($sformatf("item with tag %0h arrived with none expected",
					correlation_id_out));
			end else begin
				arrived_want = expected_reports.pop_front();
				check_field("correlation_id_out", correlation_id_out, arrived_want.tag);
				check_field("status", status, arrived_want.status);
				check_field("changed_bits", changed_bits, arrived_want.changed);
				check_field("power_on", power_on, arrived_want.power);
				check_field("brightness_out", brightness_out, arrived_want.bright);
				check_field("temp_index", temp_index, arrived_want.temp);
				check_field("timer_mode_out", timer_mode_out, arrived_want.timer_mode);
				check_field("blink_on", blink_on, arrived_want.blink);
				check_field("warm_level", warm_level, arrived_want.warm);
				check_field("cold_level", cold_level, arrived_want.cold);
			end
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("smart_light_controller_test failed");
			$finish;
		end
	end

	initial begin
		int k;
		int phase;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = 2'd0;
		cfg_wdata = '0;
		req_valid = 1'b0;
		cmd = 3'd0;
		correlation_id = 16'd0;
		is_delta = 1'b0;
		value = 8'sd0;
		on_flag = 1'b0;
		instance_req = 8'd0;
		kelvin = 16'd0;
		elapsed_ms = 16'd0;
		lamp_on = 1'b0;
		lamp_bright = 7'(FULL_BRIGHT);
		lamp_temp = 3'd0;
		shutoff_mode = 8'd0;
		shutoff_left = 0;
		blink_mode = 1'b0;
		blink_phase = 1'b0;
		blink_left = 0;
		warm_lvl = 8'd0;
		cold_lvl = 8'd0;
		cfg_blink_period = 16'd1500;
		cfg_short = 22'd300000;
		cfg_medium = 22'd600000;
		cfg_long = 22'd3600000;

		script.push_back(typed_row(command(CMD_TICK, 0, 0, 0, 0, 0, 0),
			state_after(ST_NONE, 5'd0, 0, 100, 0, 0, 0, 0, 0)));
		script.push_back(typed_row(command(CMD_POWER, 0, 0, 1, 0, 0, 0),
			state_after(ST_OK, 5'd1 << CHG_POWER, 1, 100, 0, 0, 0, 255, 0)));
		script.push_back(typed_row(command(CMD_BRIGHT, 0, 101, 0, 0, 0, 0),
			state_after(ST_RANGE, 5'd0, 1, 100, 0, 0, 0, 255, 0)));
		script.push_back(typed_row(command(CMD_BRIGHT, 0, -128, 1, 255, 65535, 65535),
			state_after(ST_RANGE, 5'd0, 1, 100, 0, 0, 0, 255, 0)));
		script.push_back(typed_row(command(CMD_BRIGHT, 0, 0, 0, 0, 0, 0),
			state_after(ST_OK, 5'd1 << CHG_BRIGHT, 1, 0, 0, 0, 0, 0, 0)));
		script.push_back(open_row(command(CMD_BRIGHT, 1, -128, 0, 0, 0, 0)));
		script.push_back(typed_row(command(CMD_BRIGHT, 1, 127, 0, 0, 0, 0),
			state_after(ST_OK, 5'd1 << CHG_BRIGHT, 1, 100, 0, 0, 0, 255, 0)));
		script.push_back(typed_row(command(CMD_TEMP_SET, 0, 0, 0, 0, 7000, 0),
			state_after(ST_OK, 5'd1 << CHG_TEMP, 1, 100, 4, 0, 0, 0, 255)));
		script.push_back(open_row(command(CMD_TEMP_UP, 0, 0, 0, 0, 0, 0)));
		script.push_back(open_row(command(CMD_TEMP_SET, 0, 0, 0, 0, 1234, 0)));
		script.push_back(open_row(command(CMD_TEMP_DOWN, 0, 0, 0, 0, 0, 0)));
		script.push_back(open_row(command(CMD_TEMP_SET, 0, 0, 0, 0, 2200, 0)));
		script.push_back(open_row(command(CMD_TEMP_DOWN, 0, 0, 0, 0, 0, 0)));
		script.push_back(open_row(command(CMD_BRIGHT, 1, 0, 0, 0, 0, 0)));
		script.push_back(typed_row(command(CMD_MODE, 0, 1, 0, 13, 0, 0),
			state_after(ST_NONE, 5'd0, 1, 100, 0, 0, 0, 255, 0)));
		script.push_back(typed_row(command(CMD_MODE, 1, -1, 0, 12, 0, 0),
			state_after(ST_RANGE, 5'd0, 1, 100, 0, 0, 0, 255, 0)));
		script.push_back(open_row(command(CMD_MODE, 0, -1, 0, 12, 0, 0)));
		script.push_back(open_row(command(CMD_TICK, 0, 0, 0, 0, 0, 65535)));
		script.push_back(open_row(command(CMD_MODE, 0, 1, 0, 12, 0, 0)));
		script.push_back(typed_row(command(CMD_TOGGLE, 0, 0, 1, 3, 0, 0),
			state_after(ST_NONE, 5'd0, 1, 100, 0, 1, 0, 255, 0)));
		script.push_back(open_row(command(CMD_TOGGLE, 0, 0, 1, 2, 0, 0)));
		script.push_back(open_row(command(CMD_TICK, 0, 0, 0, 0, 0, 0)));
		script.push_back(open_row(command(CMD_TICK, 0, 0, 0, 0, 0, 65535)));
		script.push_back(open_row(command(CMD_TOGGLE, 0, 0, 0, 2, 0, 0)));
		script.push_back(open_row(command(CMD_POWER, 0, 0, 0, 0, 0, 0)));
		script.push_back(open_row(command(CMD_POWER, 0, 0, 0, 0, 0, 0)));

		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (k = 0; k < script.size(); k++) begin
			script[k].item.correlation_id = 16'(16'hC000 + k);
			send_command(script[k]);
		end
		req_valid <= 1'b0;

		for (phase = 0; phase < PHASE_COUNT; phase++) begin
			while (expected_reports.size() != 0) @(negedge clk);
			case (phase)
				0: load_settings(16'd1, 22'd1, 22'd1, 22'd1);
				1: load_settings(16'hFFFF, 22'h3FFFFF, 22'h3FFFFF, 22'h3FFFFF);
				2: load_settings(16'd1500, 22'd300000, 22'd600000, 22'd3600000);
				default: load_settings(16'($urandom_range(4000, 1)),
					22'($urandom_range(150000, 1)), 22'($urandom_range(150000, 1)),
					22'($urandom_range(150000, 1)));
			endcase
			case (phase % 4)
				0: begin
					send_idle_pct = 0;
					stall_pct = 0;
				end
				1: begin
					send_idle_pct = 58;
					stall_pct = 0;
				end
				2: begin
					send_idle_pct = 0;
					stall_pct = 58;
				end
				default: begin
					send_idle_pct = 10;
					stall_pct = 10;
				end
			endcase
			for (k = 0; k < ITEMS_PER_PHASE; k++) begin
				send_command(open_row(random_command()));
			end
			req_valid <= 1'b0;
		end

		while (expected_reports.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		if (mismatch_count == 0) begin
			$display("smart_light_controller_test passed");
		end else begin
			$display("smart_light_controller_test failed");
		end
		$finish;
	end

endmodule
